// ===== rtl/btlv_pkg.sv =====
// Shared types and constants for the BER-TLV header parser.
// No dependencies; used by btlv_step and ber_tlv_header_parser.
`default_nettype none

package btlv_pkg;

    // Parser phase, one-hot
    typedef enum logic [5:0]
    {
        PH_TAG1  = 6'b000001,
        PH_TAG2  = 6'b000010,
        PH_LEN1  = 6'b000100,
        PH_LENX  = 6'b001000,
        PH_VALUE = 6'b010000,
        PH_HALT  = 6'b100000
    } phase_t;

    // Classification of each byte
    typedef enum logic [2:0]
    {
        KIND_TAG     = 3'd0,
        KIND_LEN     = 3'd1,
        KIND_VALUE   = 3'd2,
        KIND_END     = 3'd3,
        KIND_BADLEN  = 3'd4,
        KIND_IGNORED = 3'd5
    } kind_t;

    localparam logic [4:0] TAG_MULTI      = 5'h1F;   // low bits of a two-byte tag
    localparam int         LEN_LONG_BIT   = 7;       // long-form length flag
    localparam logic [6:0] LEN_COUNT_ONE  = 7'd1;
    localparam logic [6:0] LEN_COUNT_TWO  = 7'd2;
    localparam logic [7:0] END_ZERO       = 8'h00;
    localparam logic [7:0] END_ONES       = 8'hFF;

    typedef struct packed
    {
        phase_t      phase;
        logic [15:0] tag;
        logic [15:0] len;
        logic [1:0]  len_left;
        logic [2:0]  hdr_cnt;
        logic [15:0] val_left;
    } state_t;

    typedef struct packed
    {
        kind_t       kind;
        logic        header_done;
        logic [15:0] tag_value;
        logic [15:0] value_length;
        logic [2:0]  header_size;
        logic [15:0] total_size;
        logic        total_overflow;
        logic [15:0] value_index;
        logic        last_of_value;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/btlv_step.sv =====
// Per-byte parse step: next parser state and result item for one byte.
// Purely combinational; uses btlv_pkg types.
`default_nettype none

module btlv_step
(
    input  wire logic [7:0]        data_byte,
    input  wire logic              restart,
    input  wire btlv_pkg::state_t  cur,
    output btlv_pkg::state_t       nxt,
    output btlv_pkg::result_t      res
);

    btlv_pkg::phase_t ph;
    logic [16:0]      total;
    logic [15:0]      val_dec;

    always_comb
    begin
        ph      = restart ? btlv_pkg::PH_TAG1 : cur.phase;
        nxt     = cur;
        res     = '0;
        val_dec = cur.val_left - 16'd1;

        unique case (ph)
            btlv_pkg::PH_TAG1:
            begin
                if (data_byte == btlv_pkg::END_ZERO || data_byte == btlv_pkg::END_ONES)
                begin
                    res.kind  = btlv_pkg::KIND_END;
                    nxt.phase = btlv_pkg::PH_HALT;
                end
                else
                begin
                    nxt.tag      = {8'd0, data_byte};
                    nxt.len      = '0;
                    nxt.len_left = '0;
                    nxt.val_left = '0;
                    nxt.hdr_cnt  = 3'd1;
                    res.kind     = btlv_pkg::KIND_TAG;
                    res.tag_value = {8'd0, data_byte};
                    nxt.phase = (data_byte[4:0] == btlv_pkg::TAG_MULTI) ?
                                btlv_pkg::PH_TAG2 : btlv_pkg::PH_LEN1;
                end
            end
            btlv_pkg::PH_TAG2:
            begin
                nxt.tag       = {cur.tag[7:0], data_byte};
                nxt.hdr_cnt   = 3'd2;
                res.kind      = btlv_pkg::KIND_TAG;
                res.tag_value = {cur.tag[7:0], data_byte};
                nxt.phase     = btlv_pkg::PH_LEN1;
            end
            btlv_pkg::PH_LEN1:
            begin
                nxt.hdr_cnt   = cur.hdr_cnt + 3'd1;
                res.tag_value = cur.tag;
                if (data_byte[btlv_pkg::LEN_LONG_BIT])
                begin
                    if (data_byte[6:0] == btlv_pkg::LEN_COUNT_ONE ||
                        data_byte[6:0] == btlv_pkg::LEN_COUNT_TWO)
                    begin
                        nxt.len_left = data_byte[1:0];
                        nxt.len      = '0;
                        res.kind     = btlv_pkg::KIND_LEN;
                        nxt.phase    = btlv_pkg::PH_LENX;
                    end
                    else
                    begin
                        res.kind  = btlv_pkg::KIND_BADLEN;
                        nxt.phase = btlv_pkg::PH_HALT;
                    end
                end
                else
                begin
                    nxt.len         = {8'd0, data_byte};
                    res.kind        = btlv_pkg::KIND_LEN;
                    res.header_done = 1'b1;
                end
            end
            btlv_pkg::PH_LENX:
            begin
                nxt.len       = {cur.len[7:0], data_byte};
                nxt.hdr_cnt   = cur.hdr_cnt + 3'd1;
                nxt.len_left  = cur.len_left - 2'd1;
                res.kind      = btlv_pkg::KIND_LEN;
                res.tag_value = cur.tag;
                res.header_done = (cur.len_left == 2'd1);
            end
            btlv_pkg::PH_VALUE:
            begin
                res.kind        = btlv_pkg::KIND_VALUE;
                res.tag_value   = cur.tag;
                res.value_index = cur.len - cur.val_left;
                nxt.val_left    = val_dec;
                if (val_dec == '0)
                begin
                    res.last_of_value = 1'b1;
                    nxt.phase         = btlv_pkg::PH_TAG1;
                end
            end
            default:
            begin
                res.kind  = btlv_pkg::KIND_IGNORED;
                nxt.phase = btlv_pkg::PH_HALT;
            end
        endcase

        // Header complete: zero length ends the element right here
        if (res.header_done)
        begin
            if (nxt.len == '0)
            begin
                res.last_of_value = 1'b1;
                nxt.phase         = btlv_pkg::PH_TAG1;
            end
            else
            begin
                nxt.val_left = nxt.len;
                nxt.phase    = btlv_pkg::PH_VALUE;
            end
        end

        total = {1'b0, nxt.len} + {14'd0, nxt.hdr_cnt};
        if (res.header_done || res.kind == btlv_pkg::KIND_VALUE)
        begin
            res.value_length   = nxt.len;
            res.header_size    = nxt.hdr_cnt;
            res.total_overflow = total[16];
            res.total_size     = total[16] ? 16'd0 : total[15:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ber_tlv_header_parser.sv =====
// BER-TLV header parser top level: input register, parse step, result register.
// Depends on btlv_pkg and btlv_step.
//
// Usage:
//   Slave channel (s_*) takes one raw byte of the encoded buffer per item;
//   s_tuser set means the byte starts a new tag and resynchronizes the parser.
//   Master channel (m_*) returns exactly one result item per input byte: the
//   byte's kind and header flag in m_tuser, tag, lengths, sizes and value
//   position in m_tdata, and m_tlast on the final value byte or on a header
//   whose value length is zero.
// Pipeline: two register stages (input register, then result register);
//   m_tvalid is driven by the result register once it captures the byte's result.
//   Throughput: one byte per cycle while m_tready does not stall the output, set
//   by the single parse step between the two registers; the parser state
//   updates in the same cycle the result is captured.
// Reset: both registers empty, parser expects a first tag byte, all stored
//   tag/length/count state is zero.
// Stall: when m_tready is low the result register holds; the input register
//   still takes one more byte, then s_tready drops until the result drains.
//   Items are never dropped or repeated.
`default_nettype none

module ber_tlv_header_parser
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] restart

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // [15:0] tag_value, [31:16] value_length,
                                        // [34:32] header_size, [50:35] total_size,
                                        // [51] total_overflow, [67:52] value_index,
                                        // [71:68] zero
    output logic [3:0]       m_tuser,   // [2:0] byte_kind, [3] header_done
    output logic             m_tlast    // last_of_value
);

    // Input register
    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_restart_reg;

    // Parser state and result register
    btlv_pkg::state_t  state_reg;
    btlv_pkg::state_t  state_next;
    btlv_pkg::result_t res_reg;
    btlv_pkg::result_t res_next;
    logic              out_valid_reg;

    logic              out_free;
    logic              load;
    logic              in_take;

    assign out_free = !out_valid_reg || m_tready;
    assign load     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign in_take  = s_tvalid && s_tready;

    btlv_step u_step
    (
        .data_byte (in_byte_reg),
        .restart   (in_restart_reg),
        .cur       (state_reg),
        .nxt       (state_next),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: btlv_pkg::PH_TAG1, default: '0};
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (load)
                in_valid_reg <= 1'b0;

            if (out_free)
                out_valid_reg <= in_valid_reg;

            if (load)
                state_reg <= state_next;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg    <= s_tdata;
            in_restart_reg <= s_tuser;
        end
        if (load)
            res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0,
                       res_reg.value_index,
                       res_reg.total_overflow,
                       res_reg.total_size,
                       res_reg.header_size,
                       res_reg.value_length,
                       res_reg.tag_value};
    assign m_tuser  = {res_reg.header_done, res_reg.kind};
    assign m_tlast  = res_reg.last_of_value;

`ifndef ASSERT_OFF
    // A header with nonzero length moves the parser into the value phase
    a_hdr_to_value: assert property (@(posedge clk) disable iff (!rst_n)
        (load && res_next.header_done && !res_next.last_of_value)
        |=> (state_reg.phase == btlv_pkg::PH_VALUE))
        else $error("header with value did not enter value phase");

    // End marker halts the parser
    a_end_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (load && res_next.kind == btlv_pkg::KIND_END)
        |=> (state_reg.phase == btlv_pkg::PH_HALT))
        else $error("end marker did not halt parser");

    // In the value phase there is always at least one value byte to come
    a_value_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == btlv_pkg::PH_VALUE) |-> (state_reg.val_left != '0))
        else $error("value phase with no bytes left");

    // Overflowed total is reported as zero
    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.total_overflow) |-> (res_reg.total_size == '0))
        else $error("total size nonzero on overflow");
`endif

endmodule

`default_nettype wire

// ===== bench/btlv_parse_checker.sv =====
// Result checker for the BER-TLV header parser: watches both stream channels,
// predicts each result from the accepted bytes and compares field by field.
// Depends on btlv_pkg.
module btlv_parse_checker
    import btlv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] restart

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,    // [15:0] tag, [31:16] value length, [34:32] header size,
                                    // [50:35] total size, [51] overflow, [67:52] value index
    input  logic [3:0]  m_tuser,    // [2:0] byte_kind, [3] header_done
    input  logic        m_tlast,    // last_of_value

    output int          mismatch_count,
    output int          results_pending
);

    // predictor state
    phase_t      cur_phase;
    logic [15:0] tag_reg;
    logic [15:0] len_reg;
    logic [1:0]  len_bytes_left;
    logic [2:0]  hdr_bytes;
    logic [15:0] val_remaining;

    result_t     predicted_results[$];
    int          fail_cnt;

    assign mismatch_count  = fail_cnt;
    assign results_pending = predicted_results.size();

    function automatic void put_sizes(inout result_t r);
        logic [16:0] sum;
        sum = {14'd0, hdr_bytes} + {1'b0, len_reg};
        r.value_length   = len_reg;
        r.header_size    = hdr_bytes;
        r.total_overflow = sum[16];
        r.total_size     = sum[16] ? 16'd0 : sum[15:0];
    endfunction

    function automatic void close_header(inout result_t r);
        r.header_done = 1'b1;
        put_sizes(r);
        if (len_reg == 16'd0)
        begin
            r.last_of_value = 1'b1;
            cur_phase = PH_TAG1;
        end
        else
        begin
            val_remaining = len_reg;
            cur_phase = PH_VALUE;
        end
    endfunction

    // one byte in, one result out; advances the predictor state
    function automatic result_t classify_byte(input logic [7:0] b, input logic restart);
        result_t r;
        r = '0;
        if (restart)
            cur_phase = PH_TAG1;
        case (cur_phase)
            PH_TAG1:
            begin
                if (b == END_ZERO || b == END_ONES)
                begin
                    r.kind = KIND_END;
                    cur_phase = PH_HALT;
                end
                else
                begin
                    tag_reg = {8'd0, b};
                    len_reg = '0;
                    len_bytes_left = '0;
                    val_remaining = '0;
                    hdr_bytes = 3'd1;
                    r.kind = KIND_TAG;
                    r.tag_value = tag_reg;
                    cur_phase = (b[4:0] == TAG_MULTI) ? PH_TAG2 : PH_LEN1;
                end
            end
            PH_TAG2:
            begin
                tag_reg = {tag_reg[7:0], b};
                hdr_bytes = 3'd2;
                r.kind = KIND_TAG;
                r.tag_value = tag_reg;
                cur_phase = PH_LEN1;
            end
            PH_LEN1:
            begin
                hdr_bytes = hdr_bytes + 3'd1;
                r.tag_value = tag_reg;
                if (b[LEN_LONG_BIT])
                begin
                    if (b[6:0] == LEN_COUNT_ONE || b[6:0] == LEN_COUNT_TWO)
                    begin
                        len_bytes_left = b[1:0];
                        len_reg = '0;
                        r.kind = KIND_LEN;
                        cur_phase = PH_LENX;
                    end
                    else
                    begin
                        r.kind = KIND_BADLEN;
                        cur_phase = PH_HALT;
                    end
                end
                else
                begin
                    len_reg = {8'd0, b};
                    r.kind = KIND_LEN;
                    close_header(r);
                end
            end
            PH_LENX:
            begin
                len_reg = {len_reg[7:0], b};
                hdr_bytes = hdr_bytes + 3'd1;
                len_bytes_left = len_bytes_left - 2'd1;
                r.kind = KIND_LEN;
                r.tag_value = tag_reg;
                if (len_bytes_left == 2'd0)
                    close_header(r);
            end
            PH_VALUE:
            begin
                r.kind = KIND_VALUE;
                r.tag_value = tag_reg;
                put_sizes(r);
                r.value_index = len_reg - val_remaining;
                val_remaining = val_remaining - 16'd1;
                if (val_remaining == 16'd0)
                begin
                    r.last_of_value = 1'b1;
                    cur_phase = PH_TAG1;
                end
            end
            default:
            begin
                r.kind = KIND_IGNORED;
                cur_phase = PH_HALT;
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            fail_cnt++;
        end
    endtask

    initial
        fail_cnt = 0;

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            cur_phase      = PH_TAG1;
            tag_reg        = '0;
            len_reg        = '0;
            len_bytes_left = '0;
            hdr_bytes      = '0;
            val_remaining  = '0;
            predicted_results.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                predicted_results.push_back(classify_byte(s_tdata, s_tuser));
            if (m_tvalid && m_tready)
            begin
                if (predicted_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual kind %0d tag %0h",
                             $time, m_tuser[2:0], m_tdata[15:0]);
                    fail_cnt++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("byte_kind",      {13'd0, want.kind},       {13'd0, m_tuser[2:0]});
                    check_field("header_done",    {15'd0, want.header_done}, {15'd0, m_tuser[3]});
                    check_field("tag_value",      want.tag_value,           m_tdata[15:0]);
                    check_field("value_length",   want.value_length,        m_tdata[31:16]);
                    check_field("header_size",    {13'd0, want.header_size}, {13'd0, m_tdata[34:32]});
                    check_field("total_size",     want.total_size,          m_tdata[50:35]);
                    check_field("total_overflow", {15'd0, want.total_overflow},
                                {15'd0, m_tdata[51]});
                    check_field("value_index",    want.value_index,         m_tdata[67:52]);
                    check_field("last_of_value",  {15'd0, want.last_of_value}, {15'd0, m_tlast});
                end
            end
        end
    end

endmodule

// ===== bench/tb_ber_tlv_header_parser.sv =====
// Top of the BER-TLV header parser bench: clock, reset, byte stimulus and
// output back-pressure; the verdict comes from btlv_parse_checker.
// Depends on btlv_pkg, btlv_parse_checker and ber_tlv_header_parser.
module tb_ber_tlv_header_parser;

    import btlv_pkg::*;

    // one stream item as queued for the sender
    typedef struct packed
    {
        logic       restart;
        logic [7:0] data;
    } stream_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tuser = 1'b0;

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    int          mismatch_count;
    int          results_pending;

    stream_byte_t byte_q[$];
    int           directed_len;

    always #5 clk = ~clk;

    ber_tlv_header_parser dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    btlv_parse_checker chk
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    task automatic add_byte(input logic [7:0] b, input logic restart);
        stream_byte_t sb;
        sb.data = b;
        sb.restart = restart;
        byte_q.push_back(sb);
    endtask

    // Random noise: mostly raw bytes, with a bias toward the bytes that matter
    // to the parser (end markers, long-form length starts, two-byte tag starts).
    task automatic add_noise();
        int         n;
        logic [7:0] b;
        n = $urandom_range(1, 6);
        repeat (n)
        begin
            case ($urandom_range(0, 7))
                0:       b = END_ZERO;
                1:       b = END_ONES;
                2:       b = {1'b1, 7'($urandom_range(0, 3))};
                3:       b = {3'($urandom_range(0, 7)), TAG_MULTI};
                default: b = 8'($urandom_range(0, 255));
            endcase
            add_byte(b, $urandom_range(0, 3) == 0);
        end
    endtask

    // One well-formed element with random content. "cut" comes back set when
    // the parser is left mid-element or halted, so the next element resyncs.
    task automatic add_element(input logic restart, output logic cut);
        logic [7:0] t1;
        logic [6:0] cnt;
        int         form;
        int         len;
        int         sent;
        cut = 1'b0;
        if ($urandom_range(0, 9) < 3)
        begin
            // two-byte tag; 0xFF would be an end marker, so keep the top bits off 111
            t1 = {3'($urandom_range(0, 6)), TAG_MULTI};
            add_byte(t1, restart);
            add_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        else
        begin
            do
                t1 = 8'($urandom_range(1, 254));
            while (t1[4:0] == TAG_MULTI);
            add_byte(t1, restart);
        end

        // occasional bad long-form count (0x80 included)
        if ($urandom_range(0, 99) < 5)
        begin
            do
                cnt = 7'($urandom_range(0, 127));
            while (cnt == LEN_COUNT_ONE || cnt == LEN_COUNT_TWO);
            add_byte({1'b1, cnt}, 1'b0);
            cut = 1'b1;
            return;
        end

        form = $urandom_range(0, 2);
        if ($urandom_range(0, 4) != 0)
            len = $urandom_range(0, 8);
        else if (form == 0)
            len = $urandom_range(0, 127);
        else if (form == 1)
            len = $urandom_range(0, 255);
        else if ($urandom_range(0, 2) == 0)
            len = $urandom_range(65528, 65535);   // near or past the total size limit
        else
            len = $urandom_range(0, 65535);

        case (form)
            0:
                add_byte(8'(len), 1'b0);
            1:
            begin
                add_byte({1'b1, LEN_COUNT_ONE}, 1'b0);
                add_byte(8'(len), 1'b0);
            end
            default:
            begin
                add_byte({1'b1, LEN_COUNT_TWO}, 1'b0);
                add_byte(8'(len >> 8), 1'b0);
                add_byte(8'(len), 1'b0);
            end
        endcase

        // long values, and now and then a shorter one, are cut short and abandoned by a restart
        sent = len;
        if (len > 24 || (len > 0 && $urandom_range(0, 9) == 0))
            sent = $urandom_range(0, (len < 5) ? len - 1 : 5);
        repeat (sent)
            add_byte(8'($urandom_range(0, 255)), 1'b0);
        cut = (sent != len);
    endtask

    // Stimulus and verdict
    initial
    begin : stimulus
        logic need_sync;
        logic cut;

        // Directed part
        add_byte(8'h01, 1'b1);      // short tag, zero length: header ends the element
        add_byte(8'h00, 1'b0);
        add_byte(8'h9F, 1'b0);      // two-byte tag, one-byte long form, two values
        add_byte(8'h7F, 1'b0);
        add_byte(8'h81, 1'b0);
        add_byte(8'h02, 1'b0);
        add_byte(8'hAA, 1'b0);
        add_byte(8'h55, 1'b0);
        add_byte(8'hC1, 1'b0);      // two-byte long form, total past 65535
        add_byte(8'h82, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFE, 1'b0);
        add_byte(8'h30, 1'b1);      // restart mid-value, then bare 0x80 length
        add_byte(8'h80, 1'b0);
        add_byte(8'h12, 1'b0);      // halted: ignored
        add_byte(END_ZERO, 1'b1);   // end marker, all zeros
        add_byte(8'h55, 1'b0);
        add_byte(END_ONES, 1'b1);   // end marker, all ones
        add_byte(8'h02, 1'b1);      // long-form count of three
        add_byte(8'h83, 1'b0);
        add_byte(8'hDF, 1'b1);      // five-byte header, total exactly 65535
        add_byte(8'hFF, 1'b0);
        add_byte(8'h82, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFA, 1'b0);
        directed_len = byte_q.size();

        // Random part: mostly elements, some noise
        need_sync = 1'b1;
        while (byte_q.size() < directed_len + 750)
        begin
            if ($urandom_range(0, 99) < 20)
            begin
                add_noise();
                need_sync = 1'b1;
            end
            else
            begin
                add_element(need_sync || $urandom_range(0, 2) == 0, cut);
                need_sync = cut;
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < byte_q.size(); i++)
        begin
            if (i == directed_len || i == 500)
            begin
                // drain completely before going on
                s_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (results_pending != 0);
            end
            else if (!(i >= 300 && i < 450) && $urandom_range(0, 99) < 7)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= byte_q[i].data;
            s_tuser  <= byte_q[i].restart;
            do
                @(posedge clk);
            while (!s_tready);
        end
        s_tvalid <= 1'b0;

        do
            @(posedge clk);
        while (results_pending != 0);
        // leave room for any stray result after the last expected one
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Output back-pressure: random stalls, a quiet window with none,
    // and one long hold-off while the sender keeps offering bytes.
    initial
    begin : backpressure
        int cycle_cnt;
        int hold_left;
        cycle_cnt = 0;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cycle_cnt++;
            if (cycle_cnt == 650)
                hold_left = 60;
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (cycle_cnt >= 250 && cycle_cnt < 550)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= 7);
        end
    end

    initial
    begin : watchdog
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/btlv_pkg.sv
rtl/btlv_step.sv
rtl/ber_tlv_header_parser.sv
bench/btlv_parse_checker.sv
bench/tb_ber_tlv_header_parser.sv
